FILE: sv/sab_pkg.sv
// Shared types, register codes and helper functions for the scaled alpha blit unit.
// Depends on nothing; every other file in the folder uses it by scoped names.
package sab_pkg;

	// Register indexes on the configuration port (byte address is four times the index).
	localparam logic [2:0] REG_POS_X         = 3'd0;
	localparam logic [2:0] REG_POS_Y         = 3'd1;
	localparam logic [2:0] REG_BOX_WIDTH     = 3'd2;
	localparam logic [2:0] REG_BOX_HEIGHT    = 3'd3;
	localparam logic [2:0] REG_SOURCE_WIDTH  = 3'd4;
	localparam logic [2:0] REG_SOURCE_HEIGHT = 3'd5;
	localparam logic [2:0] REG_GLOBAL_ALPHA  = 3'd6;

	// Command codes carried in the input tuser.
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_BLEND = 1'b1;

	// Width of a scaled source coordinate and of the scaled-coordinate product.
	localparam int QUOT_W = 13;
	localparam int PROD_W = 25;
	localparam int COORD_W = 10;

	// Configuration registers as seen by the datapath.
	typedef struct packed {
		logic signed [12:0] pos_x;
		logic signed [12:0] pos_y;
		logic [11:0]        box_width;
		logic [11:0]        box_height;
		logic [12:0]        source_width;
		logic [12:0]        source_height;
		logic [7:0]         global_alpha;
	} sab_cfg_t;

	// Per-item information that travels beside the scaling divider.
	typedef struct packed {
		logic                  cmd;
		logic                  ok;
		logic [11:0]           load_index;
		logic [31:0]           data;
		logic [COORD_W-1:0]    dx;
		logic [COORD_W-1:0]    dy;
	} sab_side_t;

	// Truncating division by 255, exact for every value up to 255 * 255.
	function automatic logic [7:0] div255(input logic [15:0] x);
		logic [16:0] sum;
		sum = 17'(x) + 17'(x[15:8]) + 17'd1;
		return sum[15:8];
	endfunction

endpackage

FILE: sv/scaled_alpha_blit_unit.sv
// Scaled alpha blit unit: one item per cycle while the output is not stalled.
// A load item writes one ARGB word into the source store; a blend item yields the blended
// pixel for one box position. Latency is set by the scaling dividers, which produce one
// quotient bit per stage over thirteen stages, plus an input stage in front and range check,
// store, alpha, blend and output stages behind them, nineteen register stages in all.
// The whole pipeline advances when the output register is empty or being taken, so a new
// item is accepted every cycle unless the output is stalled. Configuration must be written
// through the APB port only while no item is in flight; the block does not enforce it.
module scaled_alpha_blit_unit #(
	parameter int SOURCE_WORDS = 4096,
	parameter int DEST_WIDTH   = 1024,
	parameter int DEST_HEIGHT  = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	// Input items
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [103:0] s_tdata,   // load_index, load_pixel, box_row, box_col, dest_pixel
	input  logic [0:0]   s_tuser,   // command
	// Result items
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [55:0]  m_tdata,   // dest_x, dest_y, new_pixel
	output logic [0:0]   m_tuser,   // write_enable
	// Configuration
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	sab_pkg::sab_cfg_t cfg_q;
	logic              adv;
	logic              cfg_wr;

	logic                          valid_s1;
	sab_pkg::sab_side_t            side_s1;
	logic [sab_pkg::PROD_W-1:0]    prod_y_s1, prod_x_s1;
	logic                          div_valid;
	sab_pkg::sab_side_t            div_side;
	logic [sab_pkg::QUOT_W-1:0]    sy, sx;
	logic                          out_write_q;
	logic [sab_pkg::COORD_W-1:0]   out_dx_q, out_dy_q;
	logic [31:0]                   out_pixel_q;

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pos_x         <= '0;
			cfg_q.pos_y         <= '0;
			cfg_q.box_width     <= '0;
			cfg_q.box_height    <= '0;
			cfg_q.source_width  <= '0;
			cfg_q.source_height <= '0;
			cfg_q.global_alpha  <= 8'd255;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				sab_pkg::REG_POS_X:         cfg_q.pos_x         <= pwdata[12:0];
				sab_pkg::REG_POS_Y:         cfg_q.pos_y         <= pwdata[12:0];
				sab_pkg::REG_BOX_WIDTH:     cfg_q.box_width     <= pwdata[11:0];
				sab_pkg::REG_BOX_HEIGHT:    cfg_q.box_height    <= pwdata[11:0];
				sab_pkg::REG_SOURCE_WIDTH:  cfg_q.source_width  <= pwdata[12:0];
				sab_pkg::REG_SOURCE_HEIGHT: cfg_q.source_height <= pwdata[12:0];
				sab_pkg::REG_GLOBAL_ALPHA:  cfg_q.global_alpha  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (paddr[4:2])
			sab_pkg::REG_POS_X:         prdata = 32'(cfg_q.pos_x);
			sab_pkg::REG_POS_Y:         prdata = 32'(cfg_q.pos_y);
			sab_pkg::REG_BOX_WIDTH:     prdata = 32'(cfg_q.box_width);
			sab_pkg::REG_BOX_HEIGHT:    prdata = 32'(cfg_q.box_height);
			sab_pkg::REG_SOURCE_WIDTH:  prdata = 32'(cfg_q.source_width);
			sab_pkg::REG_SOURCE_HEIGHT: prdata = 32'(cfg_q.source_height);
			sab_pkg::REG_GLOBAL_ALPHA:  prdata = 32'(cfg_q.global_alpha);
			default:                    prdata = '0;
		endcase
	end

	// The pipeline moves whenever the output register can take a new item.
	assign adv      = !m_tvalid || m_tready;
	assign s_tready = adv;

	sab_front #(
		.DEST_WIDTH  (DEST_WIDTH),
		.DEST_HEIGHT (DEST_HEIGHT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.cfg        (cfg_q),
		.in_valid   (s_tvalid),
		.command    (s_tuser[0]),
		.load_index (s_tdata[11:0]),
		.load_pixel (s_tdata[43:12]),
		.box_row    (s_tdata[55:44]),
		.box_col    (s_tdata[67:56]),
		.dest_pixel (s_tdata[99:68]),
		.valid_s1   (valid_s1),
		.side_s1    (side_s1),
		.prod_y_s1  (prod_y_s1),
		.prod_x_s1  (prod_x_s1)
	);

	sab_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.div_y     (cfg_q.box_height),
		.div_x     (cfg_q.box_width),
		.valid_in  (valid_s1),
		.side_in   (side_s1),
		.num_y     (prod_y_s1),
		.num_x     (prod_x_s1),
		.valid_out (div_valid),
		.side_out  (div_side),
		.quot_y    (sy),
		.quot_x    (sx)
	);

	sab_pixel #(
		.SOURCE_WORDS (SOURCE_WORDS)
	) u_pixel (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.cfg         (cfg_q),
		.valid_in    (div_valid),
		.side_in     (div_side),
		.sy          (sy),
		.sx          (sx),
		.out_valid_q (m_tvalid),
		.out_write_q (out_write_q),
		.out_dx_q    (out_dx_q),
		.out_dy_q    (out_dy_q),
		.out_pixel_q (out_pixel_q)
	);

	assign m_tuser = out_write_q;
	assign m_tdata = {4'b0000, out_pixel_q, out_dy_q, out_dx_q};

	// A written pixel is always opaque.
	a_opaque: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[51:44] == 8'hFF)
		else $error("written pixel is not opaque");

	// A result without a write carries no coordinates or pixel.
	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == '0)
		else $error("result without a write carries data");

	// Input is taken exactly when the output register can move.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow the output stage");

	// A write is impossible while compositing is disabled.
	a_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> cfg_q.global_alpha != '0)
		else $error("write produced with zero global alpha");

endmodule

FILE: sv/sab_front.sv
// Input stage of the scaled alpha blit unit: decode, box and clip checks, scale products.
// Depends on sab_pkg.
module sab_front #(
	parameter int DEST_WIDTH  = 1024,
	parameter int DEST_HEIGHT = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  sab_pkg::sab_cfg_t             cfg,
	input  logic                          in_valid,
	input  logic                          command,
	input  logic [11:0]                   load_index,
	input  logic [31:0]                   load_pixel,
	input  logic [11:0]                   box_row,
	input  logic [11:0]                   box_col,
	input  logic [31:0]                   dest_pixel,
	output logic                          valid_s1,
	output sab_pkg::sab_side_t            side_s1,
	output logic [sab_pkg::PROD_W-1:0]    prod_y_s1,
	output logic [sab_pkg::PROD_W-1:0]    prod_x_s1
);

	localparam int PROD_W = sab_pkg::PROD_W;

	logic signed [13:0] dx;
	logic signed [13:0] dy;
	logic               clipped;
	logic               rejected;

	// Destination position and clipping against the destination size.
	always_comb begin
		dx = 14'(cfg.pos_x) + $signed({2'b00, box_col});
		dy = 14'(cfg.pos_y) + $signed({2'b00, box_row});
		clipped = dx[13] || dy[13] ||
			(dx[12:0] >= 13'(DEST_WIDTH)) || (dy[12:0] >= 13'(DEST_HEIGHT));
		rejected = (cfg.box_width == '0) || (cfg.box_height == '0) ||
			(cfg.global_alpha == '0) || (box_row >= cfg.box_height) ||
			(box_col >= cfg.box_width) || clipped;
	end

	// Valid bit of the first stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload of the first stage, with the two scale products.
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1.cmd        <= command;
			side_s1.ok         <= (command == sab_pkg::CMD_BLEND) && !rejected;
			side_s1.load_index <= load_index;
			side_s1.data       <= (command == sab_pkg::CMD_LOAD) ? load_pixel : dest_pixel;
			side_s1.dx         <= dx[sab_pkg::COORD_W-1:0];
			side_s1.dy         <= dy[sab_pkg::COORD_W-1:0];
			prod_y_s1          <= PROD_W'(box_row) * PROD_W'(cfg.source_height);
			prod_x_s1          <= PROD_W'(box_col) * PROD_W'(cfg.source_width);
		end
	end

endmodule

FILE: sv/sab_divider.sv
// Pipelined restoring dividers for the nearest-neighbour scale, one quotient bit per stage.
// Depends on sab_pkg.
module sab_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  logic [11:0]                   div_y,
	input  logic [11:0]                   div_x,
	input  logic                          valid_in,
	input  sab_pkg::sab_side_t            side_in,
	input  logic [sab_pkg::PROD_W-1:0]    num_y,
	input  logic [sab_pkg::PROD_W-1:0]    num_x,
	output logic                          valid_out,
	output sab_pkg::sab_side_t            side_out,
	output logic [sab_pkg::QUOT_W-1:0]    quot_y,
	output logic [sab_pkg::QUOT_W-1:0]    quot_x
);

	localparam int QW = sab_pkg::QUOT_W;
	localparam int NW = sab_pkg::PROD_W;

	// Stage k holds the partial remainders after the top k+1 quotient bits.
	logic               valid_s [QW];
	sab_pkg::sab_side_t side_s  [QW];
	logic [NW-1:0]      rem_y_s [QW];
	logic [NW-1:0]      rem_x_s [QW];
	logic [QW-1:0]      q_y_s   [QW];
	logic [QW-1:0]      q_x_s   [QW];

	logic [NW-1:0]      rem_y_cur [QW];
	logic [NW-1:0]      rem_x_cur [QW];
	logic [QW-1:0]      q_y_cur   [QW];
	logic [QW-1:0]      q_x_cur   [QW];

	logic [NW-1:0]      rem_y_nx [QW];
	logic [NW-1:0]      rem_x_nx [QW];
	logic [QW-1:0]      q_y_nx   [QW];
	logic [QW-1:0]      q_x_nx   [QW];

	// Operands seen by each trial stage: the inputs for the first, the previous stage after.
	always_comb begin
		rem_y_cur[0] = num_y;
		rem_x_cur[0] = num_x;
		q_y_cur[0]   = '0;
		q_x_cur[0]   = '0;
		for (int k = 1; k < QW; k++) begin
			rem_y_cur[k] = rem_y_s[k-1];
			rem_x_cur[k] = rem_x_s[k-1];
			q_y_cur[k]   = q_y_s[k-1];
			q_x_cur[k]   = q_x_s[k-1];
		end
	end

	// One trial subtraction per stage and per axis.
	always_comb begin
		for (int k = 0; k < QW; k++) begin
			logic [NW-1:0] dsh_y;
			logic [NW-1:0] dsh_x;
			dsh_y = NW'(div_y) << (QW - 1 - k);
			dsh_x = NW'(div_x) << (QW - 1 - k);
			rem_y_nx[k] = rem_y_cur[k];
			rem_x_nx[k] = rem_x_cur[k];
			q_y_nx[k]   = q_y_cur[k];
			q_x_nx[k]   = q_x_cur[k];
			if (rem_y_cur[k] >= dsh_y) begin
				rem_y_nx[k]          = rem_y_cur[k] - dsh_y;
				q_y_nx[k][QW-1-k]    = 1'b1;
			end
			if (rem_x_cur[k] >= dsh_x) begin
				rem_x_nx[k]          = rem_x_cur[k] - dsh_x;
				q_x_nx[k][QW-1-k]    = 1'b1;
			end
		end
	end

	// Valid bits of the divider stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < QW; k++) begin
				valid_s[k] <= 1'b0;
			end
		end else if (adv) begin
			valid_s[0] <= valid_in;
			for (int k = 1; k < QW; k++) begin
				valid_s[k] <= valid_s[k-1];
			end
		end
	end

	// Payload of the divider stages.
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0] <= side_in;
			for (int k = 1; k < QW; k++) begin
				side_s[k] <= side_s[k-1];
			end
			for (int k = 0; k < QW; k++) begin
				rem_y_s[k] <= rem_y_nx[k];
				rem_x_s[k] <= rem_x_nx[k];
				q_y_s[k]   <= q_y_nx[k];
				q_x_s[k]   <= q_x_nx[k];
			end
		end
	end

	assign valid_out = valid_s[QW-1];
	assign side_out  = side_s[QW-1];
	assign quot_y    = q_y_s[QW-1];
	assign quot_x    = q_x_s[QW-1];

endmodule

FILE: sv/sab_pixel.sv
// Back end of the scaled alpha blit unit: store index, source store, alpha and colour blend.
// Depends on sab_pkg; holds the source store as an internal memory.
module sab_pixel #(
	parameter int SOURCE_WORDS = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  sab_pkg::sab_cfg_t             cfg,
	input  logic                          valid_in,
	input  sab_pkg::sab_side_t            side_in,
	input  logic [sab_pkg::QUOT_W-1:0]    sy,
	input  logic [sab_pkg::QUOT_W-1:0]    sx,
	output logic                          out_valid_q,
	output logic                          out_write_q,
	output logic [sab_pkg::COORD_W-1:0]   out_dx_q,
	output logic [sab_pkg::COORD_W-1:0]   out_dy_q,
	output logic [31:0]                   out_pixel_q
);

	localparam int AW = $clog2(SOURCE_WORDS);
	localparam int IW = 2 * sab_pkg::QUOT_W + 1;

	// The source store; written and read in the same stage so items stay in order.
	logic [31:0] store_mem [SOURCE_WORDS];

	logic               valid_s1, valid_s2, valid_s3, valid_s4;
	sab_pkg::sab_side_t side_s1, side_s2, side_s3, side_s4;
	sab_pkg::sab_side_t side_n1, side_n2, side_n4;
	logic [IW-1:0]      prod_s1;
	logic [sab_pkg::QUOT_W-1:0] sx_s1;
	logic [31:0]        src_s2;
	logic [15:0]        anum_s3;
	logic [23:0]        rgb_s3;
	logic [15:0]        r_num_s4, g_num_s4, b_num_s4;

	logic [IW-1:0]      idx;
	logic               idx_ok;
	logic               load_hit;
	logic [7:0]         sa;
	logic [7:0]         inv_sa;

	// Stage 1: source range check and row offset product.
	always_comb begin
		side_n1    = side_in;
		side_n1.ok = side_in.ok && (sy < cfg.source_height) && (sx < cfg.source_width);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s1    <= side_n1;
			prod_s1    <= IW'(sy) * IW'(cfg.source_width);
			sx_s1      <= sx;
		end
	end

	// Stage 2: store index, store write for loads and store read for blends.
	always_comb begin
		idx      = prod_s1 + IW'(sx_s1);
		idx_ok   = idx < IW'(SOURCE_WORDS);
		load_hit = valid_s1 && (side_s1.cmd == sab_pkg::CMD_LOAD) &&
			(32'(side_s1.load_index) < SOURCE_WORDS);
		side_n2    = side_s1;
		side_n2.ok = side_s1.ok && idx_ok;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (load_hit) begin
				store_mem[AW'(side_s1.load_index)] <= side_s1.data;
			end
			src_s2     <= store_mem[idx[AW-1:0]];
			side_s2    <= side_n2;
		end
	end

	// Stage 3: source alpha times global alpha.
	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3 <= side_s2;
			anum_s3 <= 16'(src_s2[31:24]) * 16'(cfg.global_alpha);
			rgb_s3  <= src_s2[23:0];
		end
	end

	// Stage 4: combined alpha and the three blend numerators.
	always_comb begin
		sa         = sab_pkg::div255(anum_s3);
		inv_sa     = 8'd255 - sa;
		side_n4    = side_s3;
		side_n4.ok = side_s3.ok && (sa != '0);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s4    <= side_n4;
			r_num_s4   <= 16'(rgb_s3[23:16]) * 16'(sa) + 16'(side_s3.data[23:16]) * 16'(inv_sa);
			g_num_s4   <= 16'(rgb_s3[15:8])  * 16'(sa) + 16'(side_s3.data[15:8])  * 16'(inv_sa);
			b_num_s4   <= 16'(rgb_s3[7:0])   * 16'(sa) + 16'(side_s3.data[7:0])   * 16'(inv_sa);
		end
	end

	// Stage 5: output register; a result without a write carries zero fields.
	always_ff @(posedge clk) begin
		if (adv) begin
			out_write_q <= side_s4.ok;
			out_dx_q    <= side_s4.ok ? side_s4.dx : '0;
			out_dy_q    <= side_s4.ok ? side_s4.dy : '0;
			out_pixel_q <= side_s4.ok ? {8'hFF, sab_pkg::div255(r_num_s4),
				sab_pkg::div255(g_num_s4), sab_pkg::div255(b_num_s4)} : '0;
		end
	end

	// Valid bits of the back-end stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			valid_s4    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= valid_in;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			valid_s4    <= valid_s3;
			out_valid_q <= valid_s4;
		end
	end

endmodule

FILE: tb/sv/scaled_alpha_blit_unit_tb.sv
// Testbench for the scaled alpha blit unit: drives load and blend items, predicts every result.
// Depends on sab_pkg and scaled_alpha_blit_unit, which in turn needs sab_front, sab_divider and sab_pixel.
`timescale 1ns / 100ps

module scaled_alpha_blit_unit_tb;

	localparam int STORE_WORDS = 4096;
	localparam int DEST_W      = 1024;
	localparam int DEST_H      = 1024;
	localparam int DRAIN_WAIT  = 30;

	typedef struct packed {
		logic        write_enable;
		logic [9:0]  dest_x;
		logic [9:0]  dest_y;
		logic [31:0] new_pixel;
	} blit_result_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [103:0] s_tdata;   // load_index, load_pixel, box_row, box_col, dest_pixel
	logic [0:0]   s_tuser;   // command
	logic         m_tvalid;
	logic         m_tready;
	logic [55:0]  m_tdata;   // dest_x, dest_y, new_pixel
	logic [0:0]   m_tuser;   // write_enable
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [4:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	// Local copy of the configuration and of the source store.
	logic signed [12:0] cfg_pos_x;
	logic signed [12:0] cfg_pos_y;
	logic [11:0]        cfg_box_w;
	logic [11:0]        cfg_box_h;
	logic [12:0]        cfg_src_w;
	logic [12:0]        cfg_src_h;
	logic [7:0]         cfg_alpha;
	logic [31:0]        src_words [STORE_WORDS];
	bit                 src_written [STORE_WORDS];

	blit_result_t pending_pixels [$];
	int           mismatches;
	int           items_sent;
	int           writes_seen;
	int           results_seen;
	int           sender_idle_pct;
	int           receiver_stall_pct;

	scaled_alpha_blit_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Clock with a 12 ns period.
	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Receiver readiness changes at the falling edge.
	always @(negedge clk) begin
		m_tready = ($urandom_range(99) >= receiver_stall_pct);
	end

	// Truncating blend of one colour channel.
	function automatic int mix_channel(input int s, input int d, input int a);
		return (s * a + d * (255 - a)) / 255;
	endfunction

	// Works out the blended pixel for one box position; rd_idx gives the store entry
	// that is read, or -1 where the item stops before the store.
	function automatic blit_result_t blend_pixel(input logic [11:0] row, input logic [11:0] col,
			input logic [31:0] dp, output int rd_idx);
		blit_result_t r;
		longint dx, dy, sx, sy, idx;
		int sp, sa;
		r = '0;
		rd_idx = -1;
		if (cfg_box_w == 0 || cfg_box_h == 0 || cfg_alpha == 0) return r;
		if (row >= cfg_box_h || col >= cfg_box_w) return r;
		dy = longint'(cfg_pos_y) + longint'(row);
		dx = longint'(cfg_pos_x) + longint'(col);
		if (dy < 0 || dy >= DEST_H || dx < 0 || dx >= DEST_W) return r;
		sy = (longint'(row) * longint'(cfg_src_h)) / longint'(cfg_box_h);
		sx = (longint'(col) * longint'(cfg_src_w)) / longint'(cfg_box_w);
		if (sy >= cfg_src_h || sx >= cfg_src_w) return r;
		idx = sy * longint'(cfg_src_w) + sx;
		if (idx >= STORE_WORDS) return r;
		rd_idx = int'(idx);
		sp = int'(src_words[rd_idx]);
		sa = (((sp >> 24) & 255) * int'(cfg_alpha)) / 255;
		if (sa == 0) return r;
		r.write_enable = 1'b1;
		r.dest_x = dx[9:0];
		r.dest_y = dy[9:0];
		r.new_pixel = {8'hFF,
			8'(mix_channel((sp >> 16) & 255, int'(dp[23:16]), sa)),
			8'(mix_channel((sp >> 8) & 255, int'(dp[15:8]), sa)),
			8'(mix_channel(sp & 255, int'(dp[7:0]), sa))};
		return r;
	endfunction

	// Sends one item, waits for it to be taken and records its expected result.
	// The item stays valid after it is taken so that a following item can go straight on.
	task automatic send_item(input logic cmd, input logic [11:0] load_idx,
			input logic [31:0] load_px, input logic [11:0] row, input logic [11:0] col,
			input logic [31:0] dp);
		blit_result_t r;
		int rd_idx;
		while ($urandom_range(99) < sender_idle_pct) begin
			@(negedge clk);
			s_tvalid = 1'b0;
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser = cmd;
		s_tdata = {4'b0, dp, col, row, load_px, load_idx};
		do @(posedge clk); while (!s_tready);
		if (cmd == sab_pkg::CMD_LOAD) begin
			r = '0;
			src_words[load_idx] = load_px;
			src_written[load_idx] = 1'b1;
		end else begin
			r = blend_pixel(row, col, dp, rd_idx);
		end
		pending_pixels.push_back(r);
		items_sent++;
	endtask

	// Drops the input valid once no further item follows.
	task automatic release_input();
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic send_load(input logic [11:0] idx, input logic [31:0] px);
		send_item(sab_pkg::CMD_LOAD, idx, px, 12'($urandom), 12'($urandom), $urandom);
	endtask

	// A blend never reads a store entry that has not been written: such an entry is loaded first.
	task automatic send_blend(input logic [11:0] row, input logic [11:0] col,
			input logic [31:0] dp);
		blit_result_t r;
		int rd_idx;
		r = blend_pixel(row, col, dp, rd_idx);
		if (rd_idx >= 0 && !src_written[rd_idx])
			send_load(12'(rd_idx), $urandom);
		send_item(sab_pkg::CMD_BLEND, 12'($urandom), $urandom, row, col, dp);
	endtask

	task automatic drain_results();
		release_input();
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// Writes one register through the APB port and mirrors it locally.
	task automatic write_reg(input logic [2:0] reg_idx, input logic [31:0] value);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {reg_idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		case (reg_idx)
			sab_pkg::REG_POS_X:         cfg_pos_x = value[12:0];
			sab_pkg::REG_POS_Y:         cfg_pos_y = value[12:0];
			sab_pkg::REG_BOX_WIDTH:     cfg_box_w = value[11:0];
			sab_pkg::REG_BOX_HEIGHT:    cfg_box_h = value[11:0];
			sab_pkg::REG_SOURCE_WIDTH:  cfg_src_w = value[12:0];
			sab_pkg::REG_SOURCE_HEIGHT: cfg_src_h = value[12:0];
			sab_pkg::REG_GLOBAL_ALPHA:  cfg_alpha = value[7:0];
			default: ;
		endcase
	endtask

	task automatic set_geometry(input int px, input int py, input int bw, input int bh,
			input int sw, input int sh, input int ga);
		write_reg(sab_pkg::REG_POS_X, px);
		write_reg(sab_pkg::REG_POS_Y, py);
		write_reg(sab_pkg::REG_BOX_WIDTH, bw);
		write_reg(sab_pkg::REG_BOX_HEIGHT, bh);
		write_reg(sab_pkg::REG_SOURCE_WIDTH, sw);
		write_reg(sab_pkg::REG_SOURCE_HEIGHT, sh);
		write_reg(sab_pkg::REG_GLOBAL_ALPHA, ga);
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH at %0t: %s got %h expected %h", $realtime, what, got, want);
		mismatches++;
	endtask

	// Each accepted result is compared with the oldest expectation.
	always @(posedge clk) begin
		blit_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_pixels.size() == 0) begin
				report_mismatch("result with nothing expected", m_tdata[31:0], 32'h0);
			end else begin
				want = pending_pixels.pop_front();
				if (m_tuser[0]) writes_seen++;
				if (m_tuser[0] !== want.write_enable)
					report_mismatch("write_enable", 32'(m_tuser[0]),
						32'(want.write_enable));
				if (m_tdata[9:0] !== want.dest_x)
					report_mismatch("dest_x", 32'(m_tdata[9:0]), 32'(want.dest_x));
				if (m_tdata[19:10] !== want.dest_y)
					report_mismatch("dest_y", 32'(m_tdata[19:10]), 32'(want.dest_y));
				if (m_tdata[51:20] !== want.new_pixel)
					report_mismatch("new_pixel", m_tdata[51:20], want.new_pixel);
			end
		end
	end

	// Reset values of the registers: the box is empty, so nothing is written.
	task automatic test_reset_state();
		send_load(12'd0, 32'hFFFF_FFFF);
		send_blend(12'd0, 12'd0, 32'h0);
		drain_results();
	endtask

	// Extremes of the fields and each way of suppressing a write but an empty box.
	task automatic test_directed();
		set_geometry(10, 20, 8, 8, 8, 8, 255);
		send_load(12'd0, 32'hFF12_34AB);
		send_load(12'd4095, 32'h8000_FF00);
		send_load(12'd63, 32'h0100_0000);
		send_blend(12'd0, 12'd0, 32'h0000_0000);
		send_blend(12'd7, 12'd7, 32'hFFFF_FFFF);
		send_blend(12'd8, 12'd0, 32'h1234_5678);
		send_blend(12'd0, 12'hFFF, 32'h1234_5678);
		drain_results();
		// Transparent: a faint source alpha under a weak global alpha.
		write_reg(sab_pkg::REG_GLOBAL_ALPHA, 1);
		send_blend(12'd7, 12'd7, 32'hFFFF_FFFF);
		send_blend(12'd0, 12'd0, 32'h00FF_00FF);
		drain_results();
		write_reg(sab_pkg::REG_GLOBAL_ALPHA, 0);
		send_blend(12'd0, 12'd0, 32'h0);
		drain_results();
		// Clipped on the left, right and bottom of the destination.
		set_geometry(-4096, 4095, 8, 8, 8, 8, 128);
		send_blend(12'd3, 12'd3, 32'h5555_AAAA);
		drain_results();
		set_geometry(1020, 1020, 8, 8, 8, 8, 128);
		send_blend(12'd2, 12'd3, 32'hAAAA_5555);
		send_blend(12'd4, 12'd4, 32'hAAAA_5555);
		drain_results();
		// Empty source, then a store overrun.
		set_geometry(0, 0, 4095, 4095, 0, 0, 255);
		send_blend(12'd5, 12'd5, 32'h0);
		drain_results();
		set_geometry(0, 0, 4095, 4095, 4096, 4096, 255);
		send_blend(12'd100, 12'd0, 32'h0);
		send_blend(12'd0, 12'd1000, 32'hFFFF_FFFF);
		drain_results();
	endtask

	task automatic random_geometry();
		int bw, bh, sw, sh;
		bw = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(1, 64);
		bh = ($urandom_range(9) == 0) ? $urandom_range(4095) : $urandom_range(1, 64);
		sw = ($urandom_range(9) == 0) ? $urandom_range(4096) : $urandom_range(1, 64);
		sh = ($urandom_range(9) == 0) ? $urandom_range(4096) : $urandom_range(1, 64);
		set_geometry(($urandom_range(7) == 0) ? $urandom : $urandom_range(1000),
			($urandom_range(7) == 0) ? $urandom : $urandom_range(1000),
			bw, bh, sw, sh,
			($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(200, 255));
	endtask

	// Random loads and blends over several geometries, with the given idling.
	task automatic test_random_phase(input int idle_pct, input int stall_pct, input int count);
		int n;
		logic [11:0] row, col;
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
		for (n = 0; n < count; n++) begin
			if (n % 50 == 0) begin
				drain_results();
				random_geometry();
			end
			if ($urandom_range(99) < 25) begin
				send_load(12'(($urandom_range(3) == 0) ? $urandom :
					$urandom_range(int'(cfg_src_w) * int'(cfg_src_h) > 0 ?
					(int'(cfg_src_w) * int'(cfg_src_h) - 1) % STORE_WORDS : 0)),
					$urandom);
			end else begin
				row = ($urandom_range(9) == 0 || cfg_box_h == 0) ? 12'($urandom) :
					12'($urandom_range(cfg_box_h - 1));
				col = ($urandom_range(9) == 0 || cfg_box_w == 0) ? 12'($urandom) :
					12'($urandom_range(cfg_box_w - 1));
				send_blend(row, col, $urandom);
			end
		end
		drain_results();
	endtask

	// The sender holds off mid-stream until every result is back.
	task automatic test_pause_until_empty();
		set_geometry(100, 100, 16, 16, 16, 16, 255);
		repeat (10) send_blend(12'($urandom_range(15)), 12'($urandom_range(15)), $urandom);
		release_input();
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (10) send_blend(12'($urandom_range(15)), 12'($urandom_range(15)), $urandom);
		drain_results();
	endtask

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		mismatches = 0;
		items_sent = 0;
		writes_seen = 0;
		results_seen = 0;
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		cfg_pos_x = '0;
		cfg_pos_y = '0;
		cfg_box_w = '0;
		cfg_box_h = '0;
		cfg_src_w = '0;
		cfg_src_h = '0;
		cfg_alpha = 8'd255;
		for (int i = 0; i < STORE_WORDS; i++) begin
			src_words[i] = '0;
			src_written[i] = 1'b0;
		end
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_directed();
		test_pause_until_empty();
		test_random_phase(0, 0, 220);
		test_random_phase(85, 0, 220);
		test_random_phase(0, 85, 220);
		test_random_phase(33, 33, 220);

		$display("Covered %0d items (%0d results, %0d pixel writes) over reset, directed,",
			items_sent, results_seen, writes_seen);
		$display("paused and four randomly idled phases; %0d mismatches.", mismatches);
		if (mismatches == 0 && pending_pixels.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Generous overall limit on the run.
	initial begin
		#(24_000_000);
		$display("Timeout: %0d results still expected", pending_pixels.size());
		$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: sim.f
sv/sab_pkg.sv
sv/sab_front.sv
sv/sab_divider.sv
sv/sab_pixel.sv
sv/scaled_alpha_blit_unit.sv
tb/sv/scaled_alpha_blit_unit_tb.sv
